// File: rtl/core/bthal_pkg.sv
// shared constants, codes and control structs of the block table heap allocator
package bthal_pkg;

	localparam int BLK_SHIFT      = 12;
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam int NEED_W         = 33 - BLK_SHIFT;
	localparam int CNT_W          = 11;
	localparam int ENT_W          = 3;

	localparam int ENT_TAKEN = 0;
	localparam int ENT_FIRST = 1;
	localparam int ENT_NEXT  = 2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_NOMEM   = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic REG_HEAP_BASE   = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic [31:0]      HEAP_BASE_RST   = 32'd0;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic       load;
		logic       scan_init;
		logic       scan;
		logic       mark_init;
		logic       mark;
		logic       free_init;
		logic       free_rd;
		logic       free_wr;
		logic       free_step;
		logic       clear;
		logic       res_load;
		logic [1:0] res_code;
	} bthal_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic kind;
		logic size_zero;
		logic too_big;
		logic addr_null;
		logic outside;
		logic found;
		logic exhausted;
		logic mark_last;
		logic free_more;
	} bthal_sts_t;

endpackage

// File: rtl/core/block_table_heap_allocator.sv
// top level of the first-fit block table heap allocator with its register port
// allocate: a first-fit scan of the table, then a mark of each block in the run, one table entry per cycle
// free: read then clear of each entry of the run from free_address on; rejects go straight to the result
// one request in flight at a time; the next is taken while a result waits at the output
// after reset every table entry is cleared, one entry a cycle, with req_stall high
// registers reset to heap_base 0 and block_count 1024
module block_table_heap_allocator #(
	parameter int MAX_BLOCKS = bthal_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic [31:0] size_bytes,
	input  logic [31:0] free_address,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [31:0] address
);
	import bthal_pkg::*;

	logic [31:0]      heap_base_q;
	logic [CNT_W-1:0] block_count_q;
	bthal_cmd_t       cmd;
	bthal_sts_t       sts;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= HEAP_BASE_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_HEAP_BASE:   heap_base_q   <= pwdata;
				REG_BLOCK_COUNT: block_count_q <= pwdata[CNT_W-1:0];
				default:         heap_base_q   <= heap_base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HEAP_BASE:   prdata = heap_base_q;
			REG_BLOCK_COUNT: prdata = 32'(block_count_q);
			default:         prdata = '0;
		endcase
	end

	bthal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bthal_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_base    (heap_base_q),
		.block_count  (block_count_q),
		.kind         (kind),
		.size_bytes   (size_bytes),
		.free_address (free_address),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.address      (address)
	);

endmodule

// File: rtl/core/bthal_dp.sv
// allocator datapath: request registers, block table memory, scan counters, result register
module bthal_dp #(
	parameter int MAX_BLOCKS = bthal_pkg::MAX_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [31:0]                  heap_base,
	input  logic [bthal_pkg::CNT_W-1:0]  block_count,
	input  logic                         kind,
	input  logic [31:0]                  size_bytes,
	input  logic [31:0]                  free_address,
	input  bthal_pkg::bthal_cmd_t        cmd,
	output bthal_pkg::bthal_sts_t        sts,
	output logic [1:0]                   status,
	output logic [31:0]                  address
);
	import bthal_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	logic              kind_q;
	logic [31:0]       size_q;
	logic [31:0]       addr_q;
	logic [CW-1:0]     n_q;
	logic [NEED_W-1:0] need_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     run_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     left_q;
	logic [IW-1:0]     clr_q;
	logic              rv_s1;
	logic [CW-1:0]     ridx_s1;
	logic [1:0]        status_q;
	logic [31:0]       address_q;

	logic [ENT_W-1:0]  mem [MAX_BLOCKS];
	logic [ENT_W-1:0]  rd_data;

	logic [CW-1:0]     n_nx;
	logic [32:0]       round_sum;
	logic [31:0]       rel;
	logic [CW-1:0]     ptr_inc;
	logic [CW-1:0]     start_nx;
	logic              in_range;
	logic              we;
	logic              re;
	logic [IW-1:0]     wa;
	logic [ENT_W-1:0]  wd;
	logic [ENT_W-1:0]  entry;

	assign n_nx = (32'(block_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(block_count);
	assign round_sum = {1'b0, size_bytes} + {{(33 - BLK_SHIFT){1'b0}}, {BLK_SHIFT{1'b1}}};
	assign rel       = addr_q - heap_base;
	assign ptr_inc   = ptr_q + CW'(1);
	assign in_range  = ptr_q < n_q;
	assign start_nx  = (run_q == '0) ? ridx_s1 : start_q;

	assign sts.clear_last = clr_q == IW'(MAX_BLOCKS - 1);
	assign sts.kind       = kind_q;
	assign sts.size_zero  = size_q == '0;
	assign sts.too_big    = 32'(need_q) > 32'(n_q);
	assign sts.addr_null  = addr_q == '0;
	assign sts.outside    = (addr_q < heap_base) || (32'(rel[31:BLK_SHIFT]) >= 32'(n_q));
	assign sts.found      = rv_s1 && !rd_data[ENT_TAKEN]
		&& ((32'(run_q) + 32'd1) == 32'(need_q));
	assign sts.exhausted  = !rv_s1 && !in_range;
	assign sts.mark_last  = left_q == CW'(1);
	assign sts.free_more  = rd_data[ENT_NEXT] && (ptr_inc < n_q);

	always_comb begin
		entry            = '0;
		entry[ENT_TAKEN] = 1'b1;
		entry[ENT_FIRST] = ptr_q == start_q;
		entry[ENT_NEXT]  = left_q != CW'(1);
	end

	assign we = cmd.clear || cmd.mark || cmd.free_wr;
	assign re = (cmd.scan && in_range) || cmd.free_rd;
	assign wa = cmd.clear ? clr_q : ptr_q[IW-1:0];
	assign wd = cmd.mark ? entry : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data <= mem[ptr_q[IW-1:0]];
		end
	end

	// request capture, scan and mark bookkeeping, and the result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			size_q <= size_bytes;
			addr_q <= free_address;
			n_q    <= n_nx;
			need_q <= round_sum[32:BLK_SHIFT];
		end
		ridx_s1 <= ptr_q;
		if (cmd.scan && rv_s1 && !rd_data[ENT_TAKEN]) begin
			start_q <= start_nx;
		end
		if (cmd.mark_init) begin
			left_q <= CW'(need_q);
		end else if (cmd.mark) begin
			left_q <= left_q - CW'(1);
		end
		if (cmd.res_load) begin
			status_q  <= cmd.res_code;
			address_q <= (cmd.res_code == ST_OK && kind_q == KIND_ALLOC)
				? heap_base + (32'(start_q) << BLK_SHIFT) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			run_q <= '0;
			rv_s1 <= 1'b0;
			clr_q <= '0;
		end else begin
			priority if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.free_init) begin
				ptr_q <= CW'(rel[31:BLK_SHIFT]);
			end else if (cmd.mark_init) begin
				ptr_q <= start_nx;
			end else if ((cmd.scan && in_range) || cmd.mark || cmd.free_step) begin
				ptr_q <= ptr_inc;
			end
			if (cmd.scan_init) begin
				rv_s1 <= 1'b0;
				run_q <= '0;
			end else begin
				rv_s1 <= cmd.scan && in_range;
				if (cmd.scan && rv_s1) begin
					run_q <= rd_data[ENT_TAKEN] ? '0 : run_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				clr_q <= clr_q + IW'(1);
			end
		end
	end

	assign status  = status_q;
	assign address = address_q;

endmodule

// File: rtl/core/bthal_ctrl.sv
// allocator controller: sequencing state machine and result valid
module bthal_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  res_valid,
	input  logic                  res_stall,
	input  bthal_pkg::bthal_sts_t sts,
	output bthal_pkg::bthal_cmd_t cmd
);
	import bthal_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR   = 8'b0000_0001,
		S_IDLE    = 8'b0000_0010,
		S_DECODE  = 8'b0000_0100,
		S_SCAN    = 8'b0000_1000,
		S_MARK    = 8'b0001_0000,
		S_FREE_RD = 8'b0010_0000,
		S_FREE_WR = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t     state_q;
	state_t     state_nx;
	logic [1:0] code_q;
	logic [1:0] code_nx;
	logic       res_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		code_nx  = code_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.kind == KIND_ALLOC) begin
					priority if (sts.size_zero) begin
						code_nx  = ST_IGNORED;
						state_nx = S_DONE;
					end else if (sts.too_big) begin
						code_nx  = ST_NOMEM;
						state_nx = S_DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_nx      = S_SCAN;
					end
				end else begin
					priority if (sts.addr_null) begin
						code_nx  = ST_IGNORED;
						state_nx = S_DONE;
					end else if (sts.outside) begin
						code_nx  = ST_OUTSIDE;
						state_nx = S_DONE;
					end else begin
						cmd.free_init = 1'b1;
						state_nx      = S_FREE_RD;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (sts.found) begin
					cmd.mark_init = 1'b1;
					state_nx      = S_MARK;
				end else if (sts.exhausted) begin
					code_nx  = ST_NOMEM;
					state_nx = S_DONE;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (sts.mark_last) begin
					code_nx  = ST_OK;
					state_nx = S_DONE;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_nx    = S_FREE_WR;
			end
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
				if (sts.free_more) begin
					cmd.free_step = 1'b1;
					state_nx      = S_FREE_RD;
				end else begin
					code_nx  = ST_OK;
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLEAR;
			end
		endcase
		cmd.res_code = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			code_q      <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			code_q  <= code_nx;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign res_valid = res_valid_q;

endmodule
